### src/q2e_pkg.sv
// Shared constants, angle table, pipeline data types for the quaternion to Euler block.
package q2e_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int SHW = $clog2(CORDIC_STEPS);

	// formula terms: 2^28 = 1.0
	localparam int TW = 34;
	localparam int T2W = 30;
	// CORDIC datapath and Q30 angle
	localparam int CW = 36;
	localparam int AW = 35;
	// square root unit
	localparam int SQW = 58;
	localparam int ROOT_BITS = 29;
	localparam int BPW = 5;

	localparam logic signed [TW-1:0] ONE_Q28 = TW'(64'sd1 <<< 28);
	localparam logic [SQW-1:0] ONE_Q56 = SQW'(64'd1 << 56);
	localparam logic signed [AW-1:0] PI_Q30 = 35'sd3373259426;

	localparam logic [31:0] ATAN_Q30 [0:31] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
		32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
		32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
		32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
		32'h00000001, 32'h00000000
	};

	// atan2 arguments riding along the square root chain
	typedef struct packed {
		logic signed [TW-1:0]  t0;
		logic signed [TW-1:0]  t1;
		logic signed [T2W-1:0] t2;
		logic signed [TW-1:0]  t3;
		logic signed [TW-1:0]  t4;
		logic                  clamped;
	} ang_args_t;

	typedef struct packed {
		logic [SQW-1:0] rem;
		logic [SQW-1:0] res;
	} sqrt_st_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [AW-1:0] z;
		logic                 hold;
	} lane_t;

endpackage

### src/q2e_front.sv
// Front end: products, formula terms with pitch clamp, and the radicand for the cosine.
module q2e_front (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [15:0]    quat_w,
	input  logic signed [15:0]    quat_x,
	input  logic signed [15:0]    quat_y,
	input  logic signed [15:0]    quat_z,
	output q2e_pkg::ang_args_t    args_s3,
	output q2e_pkg::sqrt_st_t     sq_s3
);
	import q2e_pkg::*;

	logic signed [31:0] p_wx_s1, p_yz_s1, p_xx_s1, p_yy_s1, p_wy_s1;
	logic signed [31:0] p_zx_s1, p_wz_s1, p_xy_s1, p_zz_s1;
	ang_args_t args_s2;
	ang_args_t args_n;
	logic signed [TW-1:0] t2_raw;
	logic signed [2*T2W-1:0] t2_sq;

	always_ff @(posedge clk) begin
		if (en) begin
			p_wx_s1 <= quat_w * quat_x;
			p_yz_s1 <= quat_y * quat_z;
			p_xx_s1 <= quat_x * quat_x;
			p_yy_s1 <= quat_y * quat_y;
			p_wy_s1 <= quat_w * quat_y;
			p_zx_s1 <= quat_z * quat_x;
			p_wz_s1 <= quat_w * quat_z;
			p_xy_s1 <= quat_x * quat_y;
			p_zz_s1 <= quat_z * quat_z;
		end
	end

	always_comb begin
		args_n.t0 = (TW'(p_wx_s1) + TW'(p_yz_s1)) <<< 1;
		args_n.t1 = ONE_Q28 - ((TW'(p_xx_s1) + TW'(p_yy_s1)) <<< 1);
		args_n.t3 = (TW'(p_wz_s1) + TW'(p_xy_s1)) <<< 1;
		args_n.t4 = ONE_Q28 - ((TW'(p_yy_s1) + TW'(p_zz_s1)) <<< 1);
		t2_raw = (TW'(p_wy_s1) - TW'(p_zx_s1)) <<< 1;
		args_n.clamped = 1'b0;
		if (t2_raw > ONE_Q28) begin
			args_n.t2 = T2W'(ONE_Q28);
			args_n.clamped = 1'b1;
		end else if (t2_raw < -ONE_Q28) begin
			args_n.t2 = T2W'(-ONE_Q28);
			args_n.clamped = 1'b1;
		end else begin
			args_n.t2 = t2_raw[T2W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			args_s2 <= args_n;
		end
	end

	// |t2| <= 2^28, so the square fits the radicand word
	assign t2_sq = args_s2.t2 * args_s2.t2;

	always_ff @(posedge clk) begin
		if (en) begin
			args_s3    <= args_s2;
			sq_s3.rem  <= ONE_Q56 - t2_sq[SQW-1:0];
			sq_s3.res  <= '0;
		end
	end

endmodule

### src/q2e_sqrt_cell.sv
// One digit of the pipelined integer square root; carries the atan2 arguments along.
module q2e_sqrt_cell (
	input  logic                        clk,
	input  logic                        en,
	input  logic [q2e_pkg::BPW-1:0]     bit_pos,
	input  q2e_pkg::sqrt_st_t           sq_in,
	input  q2e_pkg::ang_args_t          args_in,
	output q2e_pkg::sqrt_st_t           sq_q,
	output q2e_pkg::ang_args_t          args_q
);
	import q2e_pkg::*;

	logic [SQW-1:0] bitv;
	logic [SQW-1:0] trial;
	sqrt_st_t sq_n;

	always_comb begin
		bitv  = SQW'(1) << {bit_pos, 1'b0};
		trial = sq_in.res + bitv;
		if (sq_in.rem >= trial) begin
			sq_n.rem = sq_in.rem - trial;
			sq_n.res = (sq_in.res >> 1) + bitv;
		end else begin
			sq_n.rem = sq_in.rem;
			sq_n.res = sq_in.res >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_q   <= sq_n;
			args_q <= args_in;
		end
	end

endmodule

### src/q2e_cordic_cell.sv
// One vectoring CORDIC micro-rotation for one atan2 lane.
module q2e_cordic_cell (
	input  logic                     clk,
	input  logic                     en,
	input  logic [q2e_pkg::SHW-1:0]  shift,
	input  logic [31:0]              step_angle,
	input  q2e_pkg::lane_t           lane_in,
	output q2e_pkg::lane_t           lane_q
);
	import q2e_pkg::*;

	logic signed [CW-1:0] xs, ys;
	logic signed [AW-1:0] da;
	lane_t lane_n;

	always_comb begin
		xs = lane_in.x >>> shift;
		ys = lane_in.y >>> shift;
		da = $signed({{(AW-32){1'b0}}, step_angle});
		lane_n = lane_in;
		if (!lane_in.hold) begin
			if (lane_in.y > 0) begin
				lane_n.x = lane_in.x + ys;
				lane_n.y = lane_in.y - xs;
				lane_n.z = lane_in.z + da;
			end else begin
				lane_n.x = lane_in.x - ys;
				lane_n.y = lane_in.y + xs;
				lane_n.z = lane_in.z - da;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q <= lane_n;
		end
	end

endmodule

### src/quaternion_to_euler.sv
// Top level: quaternion to roll, pitch, yaw pipeline with stall control.
//
//  channel | signals                                    | dir
//  --------+--------------------------------------------+-----
//  input   | in_valid, in_stall, quat_w/x/y/z           | in
//  output  | out_valid, out_stall, roll_angle,          | out
//          | pitch_angle, yaw_angle, pitch_clamped      |
//
// One beat enters per cycle while in_stall is low; each beat passes through
// three front stages, one per root bit in the square root chain,
// an argument setup stage, one per CORDIC rotation, and the rounding output stage.
// The whole pipe moves on one enable: it holds only while a result waits on the
// output and out_stall is high, and in_stall is then raised.
// Reset clears only the per-stage valid bits; data registers are not reset.
module quaternion_to_euler (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] roll_angle,
	output logic signed [14:0] pitch_angle,
	output logic signed [15:0] yaw_angle,
	output logic               pitch_clamped
);
	import q2e_pkg::*;

	localparam int LAT = 3 + ROOT_BITS + 1 + CORDIC_STEPS + 1;
	localparam logic signed [17:0] ROLL_LIM = 18'sd25736;
	localparam logic signed [17:0] PITCH_LIM = 18'sd12868;

	logic en;
	logic [LAT-1:0] vld_q;

	ang_args_t args_c [ROOT_BITS+1];
	sqrt_st_t  sq_c   [ROOT_BITS+1];

	lane_t roll_c  [CORDIC_STEPS+1];
	lane_t pitch_c [CORDIC_STEPS+1];
	lane_t yaw_c   [CORDIC_STEPS+1];
	logic [CORDIC_STEPS:0] clamp_q;

	logic signed [15:0] roll_q;
	logic signed [14:0] pitch_q;
	logic signed [15:0] yaw_q;
	logic               flag_q;

	logic signed [17:0] roll_r, pitch_r, yaw_r;

	// setup for atan2(y, x): zero sine argument skips rotation, negative cosine
	// argument is folded into the right half plane with a pi offset
	function automatic lane_t prep(input logic signed [CW-1:0] y,
	                               input logic signed [CW-1:0] x);
		lane_t l;
		l.x = x;
		l.y = y;
		l.z = '0;
		l.hold = 1'b0;
		if (y == '0) begin
			l.hold = 1'b1;
			if (x < 0) begin
				l.z = PI_Q30;
			end
		end else if (x < 0) begin
			l.x = -x;
			l.y = -y;
			l.z = (y > 0) ? PI_Q30 : -PI_Q30;
		end
		return l;
	endfunction

	// Q30 to Q13 with round half up, then saturate
	function automatic logic signed [17:0] to_q13(input logic signed [AW-1:0] ang,
	                                             input logic signed [17:0] lim);
		logic signed [AW-1:0] sum;
		logic signed [17:0] r;
		sum = ang + AW'(65536);
		r = 18'(sum >>> 17);
		if (r > lim) begin
			r = lim;
		end else if (r < -lim) begin
			r = -lim;
		end
		return r;
	endfunction

	// stall control
	assign en        = !(vld_q[LAT-1] && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	q2e_front u_front (
		.clk     (clk),
		.en      (en),
		.quat_w  (quat_w),
		.quat_x  (quat_x),
		.quat_y  (quat_y),
		.quat_z  (quat_z),
		.args_s3 (args_c[0]),
		.sq_s3   (sq_c[0])
	);

	// square root chain, most significant root bit first
	for (genvar j = 0; j < ROOT_BITS; j++) begin : g_sqrt
		q2e_sqrt_cell u_cell (
			.clk     (clk),
			.en      (en),
			.bit_pos (BPW'(ROOT_BITS - 1 - j)),
			.sq_in   (sq_c[j]),
			.args_in (args_c[j]),
			.sq_q    (sq_c[j+1]),
			.args_q  (args_c[j+1])
		);
	end

	// argument setup; pitch cosine is the finished root
	always_ff @(posedge clk) begin
		if (en) begin
			roll_c[0]  <= prep(CW'(args_c[ROOT_BITS].t0), CW'(args_c[ROOT_BITS].t1));
			pitch_c[0] <= prep(CW'(args_c[ROOT_BITS].t2),
			                   $signed(CW'(sq_c[ROOT_BITS].res[ROOT_BITS-1:0])));
			yaw_c[0]   <= prep(CW'(args_c[ROOT_BITS].t3), CW'(args_c[ROOT_BITS].t4));
			clamp_q[0] <= args_c[ROOT_BITS].clamped;
		end
	end

	// three CORDIC lanes side by side, one rotation per stage
	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
		q2e_cordic_cell u_roll (
			.clk        (clk),
			.en         (en),
			.shift      (SHW'(k)),
			.step_angle (ATAN_Q30[k]),
			.lane_in    (roll_c[k]),
			.lane_q     (roll_c[k+1])
		);
		q2e_cordic_cell u_pitch (
			.clk        (clk),
			.en         (en),
			.shift      (SHW'(k)),
			.step_angle (ATAN_Q30[k]),
			.lane_in    (pitch_c[k]),
			.lane_q     (pitch_c[k+1])
		);
		q2e_cordic_cell u_yaw (
			.clk        (clk),
			.en         (en),
			.shift      (SHW'(k)),
			.step_angle (ATAN_Q30[k]),
			.lane_in    (yaw_c[k]),
			.lane_q     (yaw_c[k+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			clamp_q[CORDIC_STEPS:1] <= clamp_q[CORDIC_STEPS-1:0];
		end
	end

	// output stage
	always_comb begin
		roll_r  = to_q13(roll_c[CORDIC_STEPS].z, ROLL_LIM);
		pitch_r = to_q13(pitch_c[CORDIC_STEPS].z, PITCH_LIM);
		yaw_r   = to_q13(yaw_c[CORDIC_STEPS].z, ROLL_LIM);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_q  <= roll_r[15:0];
			pitch_q <= pitch_r[14:0];
			yaw_q   <= yaw_r[15:0];
			flag_q  <= clamp_q[CORDIC_STEPS];
		end
	end

	assign roll_angle    = roll_q;
	assign pitch_angle   = pitch_q;
	assign yaw_angle     = yaw_q;
	assign pitch_clamped = flag_q;

`ifndef SYNTHESIS
	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (roll_angle >= -16'sd25736) && (roll_angle <= 16'sd25736))
		else $error("roll out of range");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pitch_angle >= -15'sd12868) && (pitch_angle <= 15'sd12868))
		else $error("pitch out of range");

	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (yaw_angle >= -16'sd25736) && (yaw_angle <= 16'sd25736))
		else $error("yaw out of range");

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(vld_q))
		else $error("pipe moved during output stall");
`endif

endmodule
